// ----- rtl/core/bilinear_resize_fixed_point_defines.svh -----
// Assertion macros for the checker file of the resizer.
`ifndef BILINEAR_RESIZE_FIXED_POINT_DEFINES_SVH
`define BILINEAR_RESIZE_FIXED_POINT_DEFINES_SVH

// Clocked property, disabled while reset is asserted, with a fixed message.
`define BRFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("brfp: assertion failed");

// Clocked property, disabled while reset is asserted, with a caller message.
`define BRFP_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ----- rtl/core/brfp_pkg.sv -----
`default_nettype none

package brfp_pkg;

  // Field widths of the channels and the configuration registers.
  localparam int FUNC_W     = 1;
  localparam int COORD_W    = 12;
  localparam int PIX_W      = 8;
  localparam int SRC_DIM_W  = 9;
  localparam int DST_DIM_W  = 13;
  localparam int STEP_W     = 24;
  localparam int STEP_FRAC  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd5;

  // Register values after reset.
  localparam logic [SRC_DIM_W-1:0] RST_SRC_WIDTH  = 9'd160;
  localparam logic [SRC_DIM_W-1:0] RST_SRC_HEIGHT = 9'd120;
  localparam logic [DST_DIM_W-1:0] RST_DST_WIDTH  = 13'd320;
  localparam logic [DST_DIM_W-1:0] RST_DST_HEIGHT = 13'd240;
  localparam logic [STEP_W-1:0]    RST_X_STEP     = 24'd65536;
  localparam logic [STEP_W-1:0]    RST_Y_STEP     = 24'd65536;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

  // Four neighbour reads plus a final count step to take in the last read data.
  localparam logic [2:0] RD_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/core/brfp_if.sv -----
`default_nettype none

// Request channel: load or sample items.
interface brfp_in_if;
  logic                            valid;
  logic                            ready;
  logic [brfp_pkg::FUNC_W-1:0]     func;
  logic [brfp_pkg::COORD_W-1:0]    col;
  logic [brfp_pkg::COORD_W-1:0]    row;
  logic [brfp_pkg::PIX_W-1:0]      value;

  modport source (output valid, func, col, row, value, input ready);
  modport sink   (input valid, func, col, row, value, output ready);
endinterface

// Result channel: one result per sample item.
interface brfp_out_if;
  logic                            valid;
  logic                            ready;
  logic [brfp_pkg::PIX_W-1:0]      pixel;
  logic                            skipped;

  modport source (output valid, pixel, skipped, input ready);
  modport sink   (input valid, pixel, skipped, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bilinear_resize_fixed_point.sv -----
// Bilinear resizer for 8-bit grey images. Source pixels are written into a
// single-port-per-side frame store of SRC_MAX_WIDTH x SRC_MAX_HEIGHT bytes by
// load items; a sample item names a destination pixel and returns one result.
// A load is taken in the idle state and leaves the block ready. A sample
// inside the image passes the states MUL (two position multiplies), IDX
// (clamping and the four weight products), READ (the four neighbour reads
// through the one read port of the frame store) and DONE (result into the
// output register once it is free). A sample in the last destination row or
// column goes from MUL to DONE and is answered with pixel zero and skipped
// set. The output register holds a finished result while the input side
// carries on with loads. Configuration must be written only while the block
// is idle, which the block does not enforce; the frame store has no reset
// and a sample must only touch entries that were loaded before.
`default_nettype none

module bilinear_resize_fixed_point #(
  parameter int SRC_MAX_WIDTH  = 256,
  parameter int SRC_MAX_HEIGHT = 256,
  parameter int FRAC_BITS      = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [brfp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [brfp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  brfp_in_if.sink                                  in_i,
  brfp_out_if.source                               out_o
);

  localparam int CW     = $clog2(SRC_MAX_WIDTH);
  localparam int RW     = $clog2(SRC_MAX_HEIGHT);
  localparam int DEPTH  = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int SHIFT  = brfp_pkg::STEP_FRAC - FRAC_BITS;
  localparam int PROD_W = brfp_pkg::COORD_W + brfp_pkg::STEP_W;
  localparam int PW     = PROD_W - SHIFT;
  localparam int IW     = PW - FRAC_BITS;
  localparam int WW     = FRAC_BITS + 1;
  localparam int SW     = brfp_pkg::PIX_W + WW + 2;
  localparam int XLW    = (CW + 1 > brfp_pkg::SRC_DIM_W) ? CW + 1 : brfp_pkg::SRC_DIM_W;
  localparam int YLW    = (RW + 1 > brfp_pkg::SRC_DIM_W) ? RW + 1 : brfp_pkg::SRC_DIM_W;
  localparam int BW     = brfp_pkg::COORD_W + 1;
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

  // Configuration registers.
  logic [brfp_pkg::SRC_DIM_W-1:0] src_w_q, src_h_q;
  logic [brfp_pkg::DST_DIM_W-1:0] dst_w_q, dst_h_q;
  logic [brfp_pkg::STEP_W-1:0]    x_step_q, y_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= brfp_pkg::RST_SRC_WIDTH;
      src_h_q  <= brfp_pkg::RST_SRC_HEIGHT;
      dst_w_q  <= brfp_pkg::RST_DST_WIDTH;
      dst_h_q  <= brfp_pkg::RST_DST_HEIGHT;
      x_step_q <= brfp_pkg::RST_X_STEP;
      y_step_q <= brfp_pkg::RST_Y_STEP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        brfp_pkg::CFG_SRC_WIDTH:  src_w_q  <= cfg_data_i[brfp_pkg::SRC_DIM_W-1:0];
        brfp_pkg::CFG_SRC_HEIGHT: src_h_q  <= cfg_data_i[brfp_pkg::SRC_DIM_W-1:0];
        brfp_pkg::CFG_DST_WIDTH:  dst_w_q  <= cfg_data_i[brfp_pkg::DST_DIM_W-1:0];
        brfp_pkg::CFG_DST_HEIGHT: dst_h_q  <= cfg_data_i[brfp_pkg::DST_DIM_W-1:0];
        brfp_pkg::CFG_X_STEP:     x_step_q <= cfg_data_i[brfp_pkg::STEP_W-1:0];
        brfp_pkg::CFG_Y_STEP:     y_step_q <= cfg_data_i[brfp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  brfp_pkg::state_e state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_ready, in_xfer, out_load, mem_re, mem_we;
  logic             skip_d;

  assign in_xfer = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // A load is stored only when it falls inside the frame store.
  logic ld_in_range;
  assign ld_in_range = (BW'(in_i.col) < BW'(SRC_MAX_WIDTH))
                    && (BW'(in_i.row) < BW'(SRC_MAX_HEIGHT));
  assign mem_we = in_xfer && (in_i.func == brfp_pkg::FUNC_LOAD) && ld_in_range;

  // Next state and handshake control.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    in_ready = 1'b0;
    out_load = 1'b0;
    mem_re   = 1'b0;
    case (state_q)
      brfp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid && in_i.func == brfp_pkg::FUNC_SAMPLE) begin
          state_d = brfp_pkg::ST_MUL;
        end
      end
      brfp_pkg::ST_MUL: begin
        state_d = skip_d ? brfp_pkg::ST_DONE : brfp_pkg::ST_IDX;
      end
      brfp_pkg::ST_IDX: begin
        cnt_d   = 3'd0;
        state_d = brfp_pkg::ST_READ;
      end
      brfp_pkg::ST_READ: begin
        mem_re = (cnt_q != brfp_pkg::RD_LAST);
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == brfp_pkg::RD_LAST) begin
          state_d = brfp_pkg::ST_DONE;
        end
      end
      brfp_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = brfp_pkg::ST_IDLE;
        end
      end
      default: state_d = brfp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brfp_pkg::ST_IDLE;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sample coordinates captured on transfer.
  logic [brfp_pkg::COORD_W-1:0] col_q, row_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_i.func == brfp_pkg::FUNC_SAMPLE) begin
      col_q <= in_i.col;
      row_q <= in_i.row;
    end
  end

  // Last destination row or column is skipped.
  logic [brfp_pkg::DST_DIM_W-1:0] xlim, ylim;
  logic                           skip_q;

  assign xlim   = (dst_w_q == '0) ? '0 : dst_w_q - 1'b1;
  assign ylim   = (dst_h_q == '0) ? '0 : dst_h_q - 1'b1;
  assign skip_d = (brfp_pkg::DST_DIM_W'(col_q) >= xlim)
               || (brfp_pkg::DST_DIM_W'(row_q) >= ylim);

  // Source positions, reduced to FRAC_BITS fraction bits.
  logic [PROD_W-1:0] x_prod, y_prod;
  logic [PW-1:0]     fxp_q, fyp_q;

  assign x_prod = PROD_W'(col_q) * PROD_W'(x_step_q);
  assign y_prod = PROD_W'(row_q) * PROD_W'(y_step_q);

  always_ff @(posedge clk_i) begin
    if (state_q == brfp_pkg::ST_MUL) begin
      fxp_q  <= x_prod[PROD_W-1:SHIFT];
      fyp_q  <= y_prod[PROD_W-1:SHIFT];
      skip_q <= skip_d;
    end
  end

  // Last usable source column and row.
  logic [XLW-1:0] used_w;
  logic [YLW-1:0] used_h;
  logic [CW-1:0]  xlast;
  logic [RW-1:0]  ylast;

  always_comb begin
    if (XLW'(src_w_q) > XLW'(SRC_MAX_WIDTH)) begin
      used_w = XLW'(SRC_MAX_WIDTH);
    end else if (src_w_q == '0) begin
      used_w = XLW'(1);
    end else begin
      used_w = XLW'(src_w_q);
    end
    if (YLW'(src_h_q) > YLW'(SRC_MAX_HEIGHT)) begin
      used_h = YLW'(SRC_MAX_HEIGHT);
    end else if (src_h_q == '0) begin
      used_h = YLW'(1);
    end else begin
      used_h = YLW'(src_h_q);
    end
  end

  assign xlast = CW'(used_w - XLW'(1));
  assign ylast = RW'(used_h - YLW'(1));

  // Neighbour indices, clamped to the last column and row.
  logic [IW-1:0] px, py;
  logic [IW:0]   px1, py1;
  logic [CW-1:0] x0_d, x1_d;
  logic [RW-1:0] y0_d, y1_d;

  assign px   = fxp_q[PW-1:FRAC_BITS];
  assign py   = fyp_q[PW-1:FRAC_BITS];
  assign px1  = {1'b0, px} + (IW + 1)'(1);
  assign py1  = {1'b0, py} + (IW + 1)'(1);
  assign x0_d = (px > IW'(xlast)) ? xlast : CW'(px);
  assign x1_d = (px1 > (IW + 1)'(xlast)) ? xlast : CW'(px1);
  assign y0_d = (py > IW'(ylast)) ? ylast : RW'(py);
  assign y1_d = (py1 > (IW + 1)'(ylast)) ? ylast : RW'(py1);

  // Bilinear weights, with ONE standing for a weight of one.
  logic [WW-1:0]   fx, fy, fx1, fy1;
  logic [2*WW-1:0] p1, p2, p3, p4;

  assign fx  = {1'b0, fxp_q[FRAC_BITS-1:0]};
  assign fy  = {1'b0, fyp_q[FRAC_BITS-1:0]};
  assign fx1 = ONE - fx;
  assign fy1 = ONE - fy;
  assign p1  = (2*WW)'(fx1) * (2*WW)'(fy1);
  assign p2  = (2*WW)'(fx)  * (2*WW)'(fy1);
  assign p3  = (2*WW)'(fx1) * (2*WW)'(fy);
  assign p4  = (2*WW)'(fx)  * (2*WW)'(fy);

  logic [CW-1:0] x0_q, x1_q;
  logic [RW-1:0] y0_q, y1_q;
  logic [WW-1:0] w_q [4];

  always_ff @(posedge clk_i) begin
    if (state_q == brfp_pkg::ST_IDX) begin
      x0_q   <= x0_d;
      x1_q   <= x1_d;
      y0_q   <= y0_d;
      y1_q   <= y1_d;
      w_q[0] <= p1[2*FRAC_BITS:FRAC_BITS];
      w_q[1] <= p2[2*FRAC_BITS:FRAC_BITS];
      w_q[2] <= p3[2*FRAC_BITS:FRAC_BITS];
      w_q[3] <= p4[2*FRAC_BITS:FRAC_BITS];
    end
  end

  // Neighbour read address: bit 0 of the count picks the column, bit 1 the row.
  logic [CW-1:0] rd_x;
  logic [RW-1:0] rd_y;
  logic [AW-1:0] rd_addr, wr_addr;

  assign rd_x    = cnt_q[0] ? x1_q : x0_q;
  assign rd_y    = cnt_q[1] ? y1_q : y0_q;
  assign rd_addr = AW'(AW'(rd_y) * AW'(SRC_MAX_WIDTH)) + AW'(rd_x);
  assign wr_addr = AW'(AW'(in_i.row[RW-1:0]) * AW'(SRC_MAX_WIDTH))
                 + AW'(in_i.col[CW-1:0]);

  // Source frame store: one write and one registered read per cycle.
  logic [brfp_pkg::PIX_W-1:0] frame_mem [DEPTH];
  logic [brfp_pkg::PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= in_i.value;
    end
    if (mem_re) begin
      rd_data_q <= frame_mem[rd_addr];
    end
  end

  // Weighted sum: read data of the previous count meets its weight.
  logic [1:0]    wsel;
  logic [SW-1:0] acc_q, term;

  assign wsel = 2'(cnt_q - 3'd1);
  assign term = SW'(rd_data_q) * SW'(w_q[wsel]);

  always_ff @(posedge clk_i) begin
    if (state_q == brfp_pkg::ST_IDX) begin
      acc_q <= '0;
    end else if (state_q == brfp_pkg::ST_READ && cnt_q != 3'd0) begin
      acc_q <= acc_q + term;
    end
  end

  // Output register.
  logic [brfp_pkg::PIX_W-1:0] out_pixel_q;
  logic                       out_skip_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pixel_q <= skip_q ? '0 : acc_q[FRAC_BITS+brfp_pkg::PIX_W-1:FRAC_BITS];
      out_skip_q  <= skip_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pixel   = out_pixel_q;
  assign out_o.skipped = out_skip_q;

endmodule

`default_nettype wire

// ----- rtl/core/brfp_checker.sv -----
`default_nettype none

`include "bilinear_resize_fixed_point_defines.svh"

module brfp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire logic [brfp_pkg::FUNC_W-1:0]       in_func_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic [brfp_pkg::PIX_W-1:0]        out_pixel_i,
  input wire logic                              out_skipped_i
);

  // A result waiting for the sink holds its value.
  `BRFP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i) && $stable(out_skipped_i))

  // A sample occupies the datapath, so the input closes after its transfer.
  `BRFP_ASSERT_MSG(a_sample_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_func_i == brfp_pkg::FUNC_SAMPLE |=> !in_ready_i, "brfp: input open after sample")

  // A load never produces a result.
  `BRFP_ASSERT_MSG(a_load_silent, clk_i, rst_ni, in_valid_i && in_ready_i && in_func_i == brfp_pkg::FUNC_LOAD && !out_valid_i |=> !out_valid_i, "brfp: result after load")

  // A skipped destination pixel reads as zero.
  `BRFP_ASSERT(a_skip_zero, clk_i, rst_ni, out_valid_i && out_skipped_i |-> out_pixel_i == '0)

endmodule

bind bilinear_resize_fixed_point brfp_checker u_brfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_func_i     (in_i.func),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_pixel_i   (out_o.pixel),
  .out_skipped_i (out_o.skipped)
);

`default_nettype wire

// ----- tb/bilinear_resize_fixed_point_tb.sv -----
`timescale 1ns / 100ps

// One request on the input channel.
typedef struct packed {
  logic [brfp_pkg::FUNC_W-1:0]  func;
  logic [brfp_pkg::COORD_W-1:0] col;
  logic [brfp_pkg::COORD_W-1:0] row;
  logic [brfp_pkg::PIX_W-1:0]   value;
} resize_req_t;

// One result on the output channel.
typedef struct packed {
  logic [brfp_pkg::PIX_W-1:0] pixel;
  logic                       skipped;
} resize_res_t;

// Mirrors the frame store and the geometry registers, predicts each
// interpolated pixel and compares it with what the block returns.
class resize_scoreboard;
  localparam int FRAME_W   = 256;
  localparam int FRAME_H   = 256;
  localparam int FRAC_BITS = 8;
  localparam int ONE       = 1 << FRAC_BITS;

  logic [brfp_pkg::PIX_W-1:0]     frame [0:FRAME_W*FRAME_H-1];
  bit                             loaded [0:FRAME_W*FRAME_H-1];
  logic [brfp_pkg::SRC_DIM_W-1:0] src_w;
  logic [brfp_pkg::SRC_DIM_W-1:0] src_h;
  logic [brfp_pkg::DST_DIM_W-1:0] dst_w;
  logic [brfp_pkg::DST_DIM_W-1:0] dst_h;
  logic [brfp_pkg::STEP_W-1:0]    x_step;
  logic [brfp_pkg::STEP_W-1:0]    y_step;
  resize_res_t                    expected_pixels [$];
  int unsigned                    errors;

  function new();
    src_w  = brfp_pkg::RST_SRC_WIDTH;
    src_h  = brfp_pkg::RST_SRC_HEIGHT;
    dst_w  = brfp_pkg::RST_DST_WIDTH;
    dst_h  = brfp_pkg::RST_DST_HEIGHT;
    x_step = brfp_pkg::RST_X_STEP;
    y_step = brfp_pkg::RST_Y_STEP;
    errors = 0;
  endfunction

  function void set_register(input logic [brfp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brfp_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      brfp_pkg::CFG_SRC_WIDTH:  src_w  = data[brfp_pkg::SRC_DIM_W-1:0];
      brfp_pkg::CFG_SRC_HEIGHT: src_h  = data[brfp_pkg::SRC_DIM_W-1:0];
      brfp_pkg::CFG_DST_WIDTH:  dst_w  = data[brfp_pkg::DST_DIM_W-1:0];
      brfp_pkg::CFG_DST_HEIGHT: dst_h  = data[brfp_pkg::DST_DIM_W-1:0];
      brfp_pkg::CFG_X_STEP:     x_step = data[brfp_pkg::STEP_W-1:0];
      brfp_pkg::CFG_Y_STEP:     y_step = data[brfp_pkg::STEP_W-1:0];
      default: ;
    endcase
  endfunction

  // A destination pixel in the last row or column, or beyond, is not
  // interpolated at all.
  function bit beyond_last(input logic [brfp_pkg::COORD_W-1:0] col,
                           input logic [brfp_pkg::COORD_W-1:0] row);
    return (int'(col) >= int'(dst_w) - 1) || (int'(row) >= int'(dst_h) - 1);
  endfunction

  function int used_extent(input int size_val, input int max_val);
    if (size_val > max_val) return max_val;
    if (size_val < 1) return 1;
    return size_val;
  endfunction

  // Source neighbours and fractions of a destination pixel; the neighbour
  // indices are clamped to the last column and row of the source image.
  function void locate(input logic [brfp_pkg::COORD_W-1:0] col,
                       input logic [brfp_pkg::COORD_W-1:0] row,
                       output int x0, output int x1, output int y0, output int y1,
                       output int fx, output int fy);
    logic [63:0]     pos_x;
    logic [63:0]     pos_y;
    longint unsigned px;
    longint unsigned py;
    int              xlast;
    int              ylast;
    xlast = used_extent(int'(src_w), FRAME_W) - 1;
    ylast = used_extent(int'(src_h), FRAME_H) - 1;
    pos_x = (64'(col) * 64'(x_step)) >> (brfp_pkg::STEP_FRAC - FRAC_BITS);
    pos_y = (64'(row) * 64'(y_step)) >> (brfp_pkg::STEP_FRAC - FRAC_BITS);
    px = pos_x >> FRAC_BITS;
    py = pos_y >> FRAC_BITS;
    fx = int'(pos_x[FRAC_BITS-1:0]);
    fy = int'(pos_y[FRAC_BITS-1:0]);
    x0 = (px > xlast) ? xlast : int'(px);
    x1 = (px + 1 > xlast) ? xlast : int'(px + 1);
    y0 = (py > ylast) ? ylast : int'(py);
    y1 = (py + 1 > ylast) ? ylast : int'(py + 1);
  endfunction

  function bit is_loaded(input int x, input int y);
    return loaded[y * FRAME_W + x];
  endfunction

  // Called for every request transfer: a load updates the mirrored store,
  // a sample queues the pixel it must produce.
  function void note_input(input resize_req_t req);
    int          x0, x1, y0, y1, fx, fy;
    int unsigned w1, w2, w3, w4, sum;
    resize_res_t res;
    if (req.func == brfp_pkg::FUNC_LOAD) begin
      if (req.col < FRAME_W && req.row < FRAME_H) begin
        frame[int'(req.row) * FRAME_W + int'(req.col)]  = req.value;
        loaded[int'(req.row) * FRAME_W + int'(req.col)] = 1'b1;
      end
    end else if (beyond_last(req.col, req.row)) begin
      res.pixel   = '0;
      res.skipped = 1'b1;
      expected_pixels.push_back(res);
    end else begin
      locate(req.col, req.row, x0, x1, y0, y1, fx, fy);
      w1 = ((ONE - fx) * (ONE - fy)) >> FRAC_BITS;
      w2 = (fx * (ONE - fy)) >> FRAC_BITS;
      w3 = ((ONE - fx) * fy) >> FRAC_BITS;
      w4 = (fx * fy) >> FRAC_BITS;
      sum = frame[y0 * FRAME_W + x0] * w1 + frame[y0 * FRAME_W + x1] * w2
          + frame[y1 * FRAME_W + x0] * w3 + frame[y1 * FRAME_W + x1] * w4;
      res.pixel   = brfp_pkg::PIX_W'(sum >> FRAC_BITS);
      res.skipped = 1'b0;
      expected_pixels.push_back(res);
    end
  endfunction

  task report(input string msg);
    if (errors < 64) $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  // Called for every result transfer.
  task check_result(input logic [brfp_pkg::PIX_W-1:0] pixel, input logic skipped);
    resize_res_t want;
    if (expected_pixels.size() == 0) begin
      report($sformatf("result with none pending: pixel %0d skipped %0b", pixel, skipped));
      return;
    end
    want = expected_pixels.pop_front();
    if (pixel !== want.pixel)
      report($sformatf("pixel %0d, expected %0d", pixel, want.pixel));
    if (skipped !== want.skipped)
      report($sformatf("skipped %0b, expected %0b", skipped, want.skipped));
  endtask
endclass

module bilinear_resize_fixed_point_tb;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [brfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [brfp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  brfp_in_if  in_ch ();
  brfp_out_if out_ch ();

  resize_scoreboard sb;
  bit               hold_req  = 1'b0;
  bit               free_flow = 1'b0;
  int unsigned      idle_cycles;

  bilinear_resize_fixed_point u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Idle gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (free_flow) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [brfp_pkg::STEP_W-1:0] fit_step(input int src, input int dst);
    return brfp_pkg::STEP_W'(((src - 1) << brfp_pkg::STEP_FRAC) / (dst - 1));
  endfunction

  function automatic int pick_extent(input int typical, input int widest);
    if ($urandom_range(0, 4) != 0) return $urandom_range(2, typical);
    return $urandom_range(2, widest);
  endfunction

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned run_left;
    int unsigned hold_left;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.pixel, out_ch.skipped);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (free_flow) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (run_left != 0) begin
        run_left--;
        out_ch.ready <= 1'b1;
      end else begin
        run_left   = $urandom_range(1, 24);
        stall_left = pick_gap();
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one request after a random gap and returns at its transfer.
  // Valid stays high so that a following request can go back to back.
  task automatic send_req(input resize_req_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= req.func;
    in_ch.col   <= req.col;
    in_ch.row   <= req.row;
    in_ch.value <= req.value;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(req);
  endtask

  task automatic send_load(input int x, input int y, input logic [brfp_pkg::PIX_W-1:0] v);
    resize_req_t req;
    req.func  = brfp_pkg::FUNC_LOAD;
    req.col   = brfp_pkg::COORD_W'(x);
    req.row   = brfp_pkg::COORD_W'(y);
    req.value = v;
    send_req(req);
  endtask

  task automatic load_if_blank(input int x, input int y);
    if (!sb.is_loaded(x, y)) send_load(x, y, brfp_pkg::PIX_W'($urandom_range(0, 255)));
  endtask

  // Samples a destination pixel, first loading any neighbour that was never
  // written so that the store is read only where it holds data.
  task automatic sample_at(input int col, input int row);
    int          x0, x1, y0, y1, fx, fy;
    resize_req_t req;
    req.func  = brfp_pkg::FUNC_SAMPLE;
    req.col   = brfp_pkg::COORD_W'(col);
    req.row   = brfp_pkg::COORD_W'(row);
    req.value = brfp_pkg::PIX_W'($urandom);
    if (!sb.beyond_last(req.col, req.row)) begin
      sb.locate(req.col, req.row, x0, x1, y0, y1, fx, fy);
      load_if_blank(x0, y0);
      load_if_blank(x1, y0);
      load_if_blank(x0, y1);
      load_if_blank(x1, y1);
    end
    send_req(req);
  endtask

  // Stops offering and waits until every pending result has come back, then
  // lets the block run out for as long as the settle argument asks.
  task automatic wait_drained(input int unsigned settle);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_pixels.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [brfp_pkg::CFG_IDX_W-1:0]  idx,
                                input logic [brfp_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  // New geometry, written only once the block has gone idle.
  task automatic set_geometry(input int sw, input int sh, input int dw, input int dh,
                              input logic [brfp_pkg::STEP_W-1:0] xs,
                              input logic [brfp_pkg::STEP_W-1:0] ys);
    wait_drained(SETTLE_CYCLES);
    write_register(brfp_pkg::CFG_SRC_WIDTH, brfp_pkg::CFG_DATA_W'(sw));
    write_register(brfp_pkg::CFG_SRC_HEIGHT, brfp_pkg::CFG_DATA_W'(sh));
    write_register(brfp_pkg::CFG_DST_WIDTH, brfp_pkg::CFG_DATA_W'(dw));
    write_register(brfp_pkg::CFG_DST_HEIGHT, brfp_pkg::CFG_DATA_W'(dh));
    write_register(brfp_pkg::CFG_X_STEP, brfp_pkg::CFG_DATA_W'(xs));
    write_register(brfp_pkg::CFG_Y_STEP, brfp_pkg::CFG_DATA_W'(ys));
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_geometry();
    int                          sw, sh, dw, dh;
    int unsigned                 pick;
    logic [brfp_pkg::STEP_W-1:0] xs, ys;
    sw   = pick_extent(16, 256);
    sh   = pick_extent(16, 256);
    dw   = pick_extent(48, 4096);
    dh   = pick_extent(48, 4096);
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      xs = fit_step(sw, dw);
      ys = fit_step(sh, dh);
    end else if (pick < 9) begin
      xs = brfp_pkg::STEP_W'($urandom_range(0, 24'hFF0000));
      ys = brfp_pkg::STEP_W'($urandom_range(0, 24'hFF0000));
    end else begin
      xs = brfp_pkg::STEP_W'($urandom_range(0, 4 << brfp_pkg::STEP_FRAC));
      ys = brfp_pkg::STEP_W'($urandom_range(0, 4 << brfp_pkg::STEP_FRAC));
    end
    set_geometry(sw, sh, dw, dh, xs, ys);
  endtask

  // Mostly samples inside the destination image with random loads between
  // them; the rest are loads anywhere, edge samples and stray coordinates.
  task automatic run_random(input int unsigned count);
    int unsigned pick;
    int          last_col, last_row, used_w, used_h;
    resize_req_t req;
    last_col = int'(sb.dst_w) - 1;
    last_row = int'(sb.dst_h) - 1;
    used_w   = sb.used_extent(int'(sb.src_w), 256);
    used_h   = sb.used_extent(int'(sb.src_h), 256);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        wait_drained(0);
      end else if (pick < 20) begin
        send_load($urandom_range(0, used_w - 1), $urandom_range(0, used_h - 1),
                  brfp_pkg::PIX_W'($urandom_range(0, 255)));
      end else if (pick < 28) begin
        send_load($urandom_range(0, 4095), $urandom_range(0, 4095),
                  brfp_pkg::PIX_W'($urandom_range(0, 255)));
      end else if (pick < 36) begin
        sample_at($urandom_range(0, 4095), $urandom_range(0, 4095));
      end else if (pick < 40) begin
        sample_at(last_col, $urandom_range(0, last_row));
      end else if (pick < 44) begin
        sample_at($urandom_range(0, last_col), last_row);
      end else begin
        sample_at($urandom_range(0, last_col - 1), $urandom_range(0, last_row - 1));
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= brfp_pkg::CFG_SRC_WIDTH;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= brfp_pkg::FUNC_LOAD;
    in_ch.col   <= '0;
    in_ch.row   <= '0;
    in_ch.value <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: store corner, loads outside the store, clamping at the
    // last source column and row, and samples in the last destination row
    // and column or beyond.
    send_load(255, 255, 8'hFF);
    send_load(4095, 4095, 8'hAA);
    send_load(256, 0, 8'h55);
    send_load(0, 256, 8'h5A);
    sample_at(0, 0);
    sample_at(318, 237);
    sample_at(319, 0);
    sample_at(0, 239);
    sample_at(4095, 4095);

    // Half-pixel steps: equal weights, full-scale sum, and a zero pixel.
    set_geometry(3, 3, 5, 5, fit_step(3, 5), fit_step(3, 5));
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) send_load(x, y, 8'hFF);
    end
    sample_at(1, 1);
    sample_at(3, 3);
    send_load(0, 0, 8'h00);
    sample_at(1, 0);

    // Extreme geometries.
    set_geometry(256, 256, 4096, 4096, fit_step(256, 4096), fit_step(256, 4096));
    run_random(24);
    set_geometry(2, 2, 2, 2, fit_step(2, 2), fit_step(2, 2));
    run_random(16);
    set_geometry(256, 2, 2, 4096, 24'hFF0000, 24'h000000);
    run_random(24);

    // Random geometries; the first has the result side held off for a long
    // stretch, a later one runs with no idling at all.
    for (int p = 0; p < 7; p++) begin
      random_geometry();
      if (p == 0) hold_req = 1'b1;
      if (p == 3) free_flow = 1'b1;
      run_random(30);
      free_flow = 1'b0;
    end

    wait_drained(SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
